// File: rtl/msgf_pkg.sv
// ----------------------------------------------------------------------------
// msgf_pkg
// Shared types and codes for the missing sample gap filler.
// ----------------------------------------------------------------------------
package msgf_pkg;

  localparam int CntW = 6;

  localparam logic REG_MISSING_CODE = 1'b0;
  localparam logic REG_GAP_WARN     = 1'b1;

  typedef enum logic [1:0] {
    PH_LEAD, PH_ONE, PH_NORMAL, PH_HOLD
  } phase_e;

  typedef enum logic [1:0] {
    CS_IDLE, CS_NEXT, CS_CALC, CS_EMIT
  } ctl_state_e;

  typedef enum logic [2:0] {
    SG_LEAD0, SG_LEADI, SG_HOLDA, SG_ORIG1, SG_GAPI, SG_HOLDB, SG_ORIG2
  } seg_e;

  typedef enum logic [1:0] {
    FK_ORIG, FK_INTERP, FK_EXTRAP, FK_HELD
  } fill_kind_e;

  typedef enum logic [1:0] {
    OP_EXTRAP, OP_LEADI, OP_GAPI
  } calc_op_e;

  typedef enum logic [1:0] {
    SRC_RES, SRC_HOLD, SRC_V, SRC_FW
  } src_e;

  typedef enum logic [1:0] {
    HS_LV, HS_FV, HS_V
  } hold_sel_e;

  typedef enum logic [1:0] {
    LV_KEEP, LV_V, LV_FV, LV_CLR
  } lv_op_e;

  typedef enum logic [1:0] {
    FV_KEEP, FV_V, FV_CLR
  } fv_op_e;

  typedef enum logic [1:0] {
    DC_IDLE, DC_MUL, DC_DIV, DC_FIN
  } dp_calc_e;

  typedef struct packed {
    logic            acc;
    hold_sel_e       hold_sel;
    lv_op_e          lv_op;
    fv_op_e          fv_op;
    logic            gb_fv;
    logic            start;
    calc_op_e        op;
    logic [CntW-1:0] k;
    logic [CntW-1:0] den;
    logic            emit;
    src_e            src;
    fill_kind_e      kind;
    logic            lg;
    logic            run_end;
    logic            set_end;
  } ctl_cmd_t;

  typedef struct packed {
    logic miss;
    logic calc_done;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/missing_sample_gap_filler.sv
// ----------------------------------------------------------------------------
// missing_sample_gap_filler
// Replaces runs of missing samples by linear interpolation, leading-run
// extrapolation, or hold of the last valid value.
// ----------------------------------------------------------------------------
// One sample is taken per item; runs of the missing code are withheld and
// replayed when the run closes. An item with no results is only accepted;
// otherwise the sequencer accepts it, scans its segments in order past the
// empty ones, and steps through NEXT and EMIT for each original or held
// result. Each interpolated or extrapolated result also passes through
// CALC, where the rounding divider develops one quotient bit per cycle.
// Output stalls hold the sequencer in EMIT. A new item is taken once all
// results of the previous one have entered the output register.
module missing_sample_gap_filler #(
  parameter int MAX_GAP     = 31,
  parameter int SAMPLE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // value
  output logic [3:0]  m_axis_tuser,  // fill_kind[1:0], long_gap, set_end
  output logic        m_axis_tlast
);
  import msgf_pkg::*;

  localparam int VB = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;

  logic [31:0] missing_code_q;
  logic [4:0]  warn_q;
  ctl_cmd_t    cmd;
  dp_stat_t    stat;
  logic [1:0]  kind;
  logic        lg, set_end;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      missing_code_q <= '0;
      warn_q         <= 5'd5;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MISSING_CODE: missing_code_q <= cfg_data_i;
        REG_GAP_WARN:     warn_q         <= cfg_data_i[4:0];
        default:          warn_q         <= warn_q;
      endcase
    end
  end

  msgf_ctrl #(.MAX_GAP(MAX_GAP)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .warn_i     (warn_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_last_i  (s_axis_tlast),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  msgf_dp #(.VB(VB)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .missing_code_i (missing_code_q),
    .sample_i       (s_axis_tdata),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .value_o        (m_axis_tdata),
    .kind_o         (kind),
    .lg_o           (lg),
    .run_end_o      (m_axis_tlast),
    .set_end_o      (set_end)
  );

  assign m_axis_tuser = {set_end, lg, kind};

`ifndef ASSERT_OFF
  a_set_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[3]) |-> m_axis_tlast)
    else $error("set end without run end");

  a_orig_no_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1:0] == FK_ORIG) |-> !m_axis_tuser[2])
    else $error("original sample flagged as long gap");
`endif

endmodule

// File: rtl/msgf_ctrl.sv
// ----------------------------------------------------------------------------
// msgf_ctrl
// Sequencer: tracks runs, plans the result segments of each item and steps
// through them one result at a time.
// ----------------------------------------------------------------------------
module msgf_ctrl #(
  parameter int MAX_GAP = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [4:0]        warn_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_last_i,
  input  msgf_pkg::dp_stat_t stat_i,
  output msgf_pkg::ctl_cmd_t cmd_o
);
  import msgf_pkg::*;

  localparam logic [CntW-1:0] MaxGap = CntW'(MAX_GAP);
  localparam logic [CntW-1:0] MaxGapP1 = CntW'(MAX_GAP + 1);

  ctl_state_e      state_q, state_d;
  phase_e          phase_q;
  seg_e            seg_q;
  logic [CntW-1:0] lead_q, gap_q, pl_q, pg_q, k_q;
  logic [CntW-1:0] cnt_q [7];
  logic [CntW:0]   tot_q;
  logic            fin_q, lgl_q, lga_q, lgg_q, lgb_q;

  logic            acc;
  logic [CntW-1:0] p_cnt [7];
  logic [CntW:0]   p_tot;
  logic            p_lgl, p_lga, p_lgg, p_lgb;
  phase_e          p_phase;
  logic [CntW-1:0] p_lead, p_gap;
  hold_sel_e       p_hold;
  lv_op_e          p_lv;
  fv_op_e          p_fv;
  logic            p_gbfv;
  logic [CntW-1:0] cur_cnt;
  logic            seg_calc;
  logic [CntW-1:0] wrn;

  assign in_ready_o = (state_q == CS_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign wrn        = {1'b0, warn_i};
  assign cur_cnt    = cnt_q[seg_q];
  assign seg_calc   = (seg_q == SG_LEAD0) || (seg_q == SG_LEADI) || (seg_q == SG_GAPI);

  // plan of the results for the item on the input
  always_comb begin
    for (int i = 0; i < 7; i++) begin
      p_cnt[i] = '0;
    end
    p_lgl   = 1'b0;
    p_lga   = 1'b0;
    p_lgg   = 1'b0;
    p_lgb   = 1'b0;
    p_phase = phase_q;
    p_lead  = lead_q;
    p_gap   = gap_q;
    p_hold  = HS_LV;
    p_lv    = LV_KEEP;
    p_fv    = FV_KEEP;
    p_gbfv  = 1'b0;
    case (phase_q)
      PH_LEAD: begin
        if (stat_i.miss) begin
          if (in_last_i || lead_q >= MaxGap) begin
            p_cnt[SG_HOLDB] = lead_q + 1'b1;
            p_lgb   = (lead_q + 1'b1) > wrn;
            p_lead  = '0;
            p_phase = PH_HOLD;
          end else begin
            p_lead = lead_q + 1'b1;
          end
        end else if (lead_q == '0) begin
          p_cnt[SG_ORIG2] = CntW'(1);
          p_lv    = LV_V;
          p_phase = PH_NORMAL;
        end else if (in_last_i) begin
          p_cnt[SG_HOLDB] = lead_q;
          p_lgb  = lead_q > wrn;
          p_hold = HS_V;
          p_cnt[SG_ORIG2] = CntW'(1);
        end else begin
          p_fv    = FV_V;
          p_gap   = '0;
          p_phase = PH_ONE;
        end
      end
      PH_ONE: begin
        if (stat_i.miss) begin
          if (in_last_i || gap_q >= MaxGap) begin
            p_cnt[SG_HOLDA] = lead_q;
            p_lga  = lead_q > wrn;
            p_cnt[SG_ORIG1] = CntW'(1);
            p_cnt[SG_HOLDB] = gap_q + 1'b1;
            p_lgb  = (gap_q + 1'b1) > wrn;
            p_hold = HS_FV;
            p_lv   = LV_FV;
            p_lead = '0;
            p_gap  = '0;
            p_phase = PH_HOLD;
          end else begin
            p_gap = gap_q + 1'b1;
          end
        end else begin
          p_cnt[SG_LEAD0] = CntW'(1);
          p_cnt[SG_LEADI] = lead_q - 1'b1;
          p_lgl  = lead_q > wrn;
          p_cnt[SG_ORIG1] = CntW'(1);
          p_cnt[SG_GAPI]  = gap_q;
          p_lgg  = gap_q > wrn;
          p_cnt[SG_ORIG2] = CntW'(1);
          p_gbfv = 1'b1;
          p_lv   = LV_V;
          p_lead = '0;
          p_gap  = '0;
          p_phase = PH_NORMAL;
        end
      end
      PH_NORMAL: begin
        if (stat_i.miss) begin
          if (in_last_i || gap_q >= MaxGap) begin
            p_cnt[SG_HOLDB] = gap_q + 1'b1;
            p_lgb   = (gap_q + 1'b1) > wrn;
            p_gap   = '0;
            p_phase = PH_HOLD;
          end else begin
            p_gap = gap_q + 1'b1;
          end
        end else begin
          p_cnt[SG_GAPI]  = gap_q;
          p_lgg = gap_q > wrn;
          p_cnt[SG_ORIG2] = CntW'(1);
          p_lv  = LV_V;
          p_gap = '0;
        end
      end
      default: begin
        if (stat_i.miss) begin
          p_cnt[SG_HOLDB] = CntW'(1);
          p_lgb = MaxGapP1 > wrn;
        end else begin
          p_cnt[SG_ORIG2] = CntW'(1);
          p_lv    = LV_V;
          p_phase = PH_NORMAL;
        end
      end
    endcase
    if (in_last_i) begin
      p_phase = PH_LEAD;
      p_lead  = '0;
      p_gap   = '0;
      p_lv    = LV_CLR;
      p_fv    = FV_CLR;
    end
    p_tot = '0;
    for (int i = 0; i < 7; i++) begin
      p_tot = p_tot + (CntW+1)'(p_cnt[i]);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (acc && p_tot != '0) state_d = CS_NEXT;
      end
      CS_NEXT: begin
        if (cur_cnt != '0) state_d = seg_calc ? CS_CALC : CS_EMIT;
      end
      CS_CALC: begin
        if (stat_i.calc_done) state_d = CS_EMIT;
      end
      CS_EMIT: begin
        if (stat_i.out_free) state_d = (tot_q == (CntW+1)'(1)) ? CS_IDLE : CS_NEXT;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.acc      = acc;
    cmd_o.hold_sel = p_hold;
    cmd_o.lv_op    = p_lv;
    cmd_o.fv_op    = p_fv;
    cmd_o.gb_fv    = p_gbfv;
    case (seg_q)
      SG_LEAD0: begin
        cmd_o.op  = OP_EXTRAP;
        cmd_o.k   = pl_q;
        cmd_o.den = pg_q + 1'b1;
        cmd_o.src = SRC_RES;  cmd_o.kind = FK_EXTRAP; cmd_o.lg = lgl_q;
      end
      SG_LEADI: begin
        cmd_o.op  = OP_LEADI;
        cmd_o.k   = k_q;
        cmd_o.den = pl_q;
        cmd_o.src = SRC_RES;  cmd_o.kind = FK_INTERP; cmd_o.lg = lgl_q;
      end
      SG_HOLDA: begin
        cmd_o.src = SRC_HOLD; cmd_o.kind = FK_HELD;   cmd_o.lg = lga_q;
      end
      SG_ORIG1: begin
        cmd_o.src = SRC_FW;   cmd_o.kind = FK_ORIG;
      end
      SG_GAPI: begin
        cmd_o.op  = OP_GAPI;
        cmd_o.k   = k_q;
        cmd_o.den = pg_q + 1'b1;
        cmd_o.src = SRC_RES;  cmd_o.kind = FK_INTERP; cmd_o.lg = lgg_q;
      end
      SG_HOLDB: begin
        cmd_o.src = SRC_HOLD; cmd_o.kind = FK_HELD;   cmd_o.lg = lgb_q;
      end
      default: begin
        cmd_o.src = SRC_V;    cmd_o.kind = FK_ORIG;
      end
    endcase
    cmd_o.start   = (state_q == CS_NEXT) && (cur_cnt != '0) && seg_calc;
    cmd_o.emit    = (state_q == CS_EMIT) && stat_i.out_free;
    cmd_o.run_end = (tot_q == (CntW+1)'(1));
    cmd_o.set_end = fin_q && (tot_q == (CntW+1)'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      phase_q <= PH_LEAD;
      seg_q   <= SG_LEAD0;
      lead_q  <= '0;
      gap_q   <= '0;
      pl_q    <= '0;
      pg_q    <= '0;
      k_q     <= '0;
      tot_q   <= '0;
      fin_q   <= 1'b0;
      lgl_q   <= 1'b0;
      lga_q   <= 1'b0;
      lgg_q   <= 1'b0;
      lgb_q   <= 1'b0;
      for (int i = 0; i < 7; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (acc) begin
        phase_q <= p_phase;
        lead_q  <= p_lead;
        gap_q   <= p_gap;
        pl_q    <= lead_q;
        pg_q    <= gap_q;
        seg_q   <= SG_LEAD0;
        k_q     <= CntW'(1);
        tot_q   <= p_tot;
        fin_q   <= in_last_i;
        lgl_q   <= p_lgl;
        lga_q   <= p_lga;
        lgg_q   <= p_lgg;
        lgb_q   <= p_lgb;
        for (int i = 0; i < 7; i++) begin
          cnt_q[i] <= p_cnt[i];
        end
      end else if (state_q == CS_NEXT && cur_cnt == '0) begin
        seg_q <= seg_e'(3'(seg_q + 3'd1));
        k_q   <= CntW'(1);
      end else if (cmd_o.emit) begin
        cnt_q[seg_q] <= cur_cnt - 1'b1;
        tot_q        <= tot_q - 1'b1;
        k_q          <= k_q + 1'b1;
      end
    end
  end

endmodule

// File: rtl/msgf_dp.sv
// ----------------------------------------------------------------------------
// msgf_dp
// Datapath: sample registers, bit-serial rounding divider for fills, and
// the result register.
// ----------------------------------------------------------------------------
module msgf_dp #(
  parameter int VB = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        missing_code_i,
  input  logic [31:0]        sample_i,
  input  msgf_pkg::ctl_cmd_t cmd_i,
  output msgf_pkg::dp_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        value_o,
  output logic [1:0]         kind_o,
  output logic               lg_o,
  output logic               run_end_o,
  output logic               set_end_o
);
  import msgf_pkg::*;

  localparam int DW = VB + 6;
  localparam int CW = $clog2(DW + 1);
  localparam logic signed [VB+7:0] Hi = (VB+8)'((64'd1 << (VB - 1)) - 64'd1);
  localparam logic signed [VB+7:0] Lo = ~Hi;

  logic signed [VB-1:0] samp;
  logic signed [VB-1:0] lv_q, fv_q, v_q, fw_q, gb_q, hold_q, s0_q, res_q;
  dp_calc_e             dc_q;
  logic signed [VB:0]   diff_q;
  logic signed [VB-1:0] base_q;
  logic [CntW-1:0]      kk_q, den_q;
  logic                 neg_q, ext_q;
  logic [DW-1:0]        dvd_q;
  logic [CntW-1:0]      rem_q;
  logic [CW-1:0]        it_q;

  logic signed [VB-1:0] a_sel, b_sel;
  logic [VB-1:0]        mag;
  logic [CntW:0]        trial;
  logic                 qbit;
  logic signed [VB+6:0] qs;
  logic signed [VB+7:0] sum;
  logic signed [VB-1:0] sat_v;
  logic signed [VB-1:0] out_src;
  logic                 ov_q;
  logic [31:0]          val_q;
  logic [1:0]           kind_q;
  logic                 lg_q, re_q, se_q;

  assign samp = signed'(sample_i[VB-1:0]);

  assign stat_o.miss      = (sample_i[VB-1:0] == missing_code_i[VB-1:0]);
  assign stat_o.calc_done = (dc_q == DC_FIN);
  assign stat_o.out_free  = !ov_q || out_ready_i;

  always_comb begin
    case (cmd_i.op)
      OP_EXTRAP: begin a_sel = fw_q; b_sel = v_q;  end
      OP_LEADI:  begin a_sel = s0_q; b_sel = fw_q; end
      default:   begin a_sel = gb_q; b_sel = v_q;  end
    endcase
  end

  // extrapolation steps back from the first valid sample
  assign mag   = neg_q ? VB'(-diff_q) : VB'(diff_q);
  assign trial = {rem_q, dvd_q[DW-1]};
  assign qbit  = (trial >= {1'b0, den_q});
  assign qs    = (neg_q ^ ext_q) ? -(VB+7)'({1'b0, dvd_q}) : (VB+7)'({1'b0, dvd_q});
  assign sum   = (VB+8)'(base_q) + (VB+8)'(qs);
  assign sat_v = (sum > Hi) ? VB'(Hi) : ((sum < Lo) ? VB'(Lo) : VB'(sum));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q <= DC_IDLE;
      lv_q <= '0;
      fv_q <= '0;
      ov_q <= 1'b0;
    end else begin
      case (dc_q)
        DC_IDLE: if (cmd_i.start) dc_q <= DC_MUL;
        DC_MUL:  dc_q <= DC_DIV;
        DC_DIV:  if (it_q == CW'(1)) dc_q <= DC_FIN;
        DC_FIN:  dc_q <= DC_IDLE;
        default: dc_q <= DC_IDLE;
      endcase
      if (cmd_i.acc) begin
        case (cmd_i.lv_op)
          LV_V:    lv_q <= samp;
          LV_FV:   lv_q <= fv_q;
          LV_CLR:  lv_q <= '0;
          default: lv_q <= lv_q;
        endcase
        case (cmd_i.fv_op)
          FV_V:    fv_q <= samp;
          FV_CLR:  fv_q <= '0;
          default: fv_q <= fv_q;
        endcase
      end
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_comb begin
    case (cmd_i.src)
      SRC_RES:  out_src = res_q;
      SRC_HOLD: out_src = hold_q;
      SRC_FW:   out_src = fw_q;
      default:  out_src = v_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      v_q  <= samp;
      fw_q <= fv_q;
      gb_q <= cmd_i.gb_fv ? fv_q : lv_q;
      case (cmd_i.hold_sel)
        HS_FV:   hold_q <= fv_q;
        HS_V:    hold_q <= samp;
        default: hold_q <= lv_q;
      endcase
    end
    if (cmd_i.start) begin
      diff_q <= (VB+1)'(b_sel) - (VB+1)'(a_sel);
      base_q <= a_sel;
      kk_q   <= cmd_i.k;
      den_q  <= cmd_i.den;
      ext_q  <= (cmd_i.op == OP_EXTRAP);
    end
    if (dc_q == DC_MUL) begin
      dvd_q <= DW'(mag) * DW'(kk_q) + DW'(den_q >> 1);
      rem_q <= '0;
      it_q  <= CW'(DW);
    end else if (dc_q == DC_DIV) begin
      rem_q <= qbit ? CntW'(trial - {1'b0, den_q}) : CntW'(trial);
      dvd_q <= {dvd_q[DW-2:0], qbit};
      it_q  <= it_q - 1'b1;
    end else if (cmd_i.start) begin
      neg_q <= ((VB+1)'(b_sel) - (VB+1)'(a_sel)) < 0;
    end
    if (dc_q == DC_FIN) begin
      res_q <= sat_v;
      if (ext_q) s0_q <= sat_v;
    end
    if (cmd_i.emit) begin
      val_q  <= 32'(out_src);
      kind_q <= cmd_i.kind;
      lg_q   <= cmd_i.lg;
      re_q   <= cmd_i.run_end;
      se_q   <= cmd_i.set_end;
    end
  end

  assign out_valid_o = ov_q;
  assign value_o     = val_q;
  assign kind_o      = kind_q;
  assign lg_o        = lg_q;
  assign run_end_o   = re_q;
  assign set_end_o   = se_q;

endmodule
